// ===== rtl/heq_pkg.sv =====
// Shared types and constants of the histogram equaliser.
`timescale 1ns / 1ps

package heq_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned BINS    = 256;
  localparam int unsigned COUNT_W = 26;
  // 255*cum + total/2 stays below 256*total, so 34 bits hold the numerator
  localparam int unsigned NUM_W   = 34;

  localparam int unsigned MAX_PIXELS = 33554432;
  localparam int unsigned COUNT_CAP  = (2 ** COUNT_W) - 1;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT =
    (MAX_PIXELS > COUNT_CAP) ? COUNT_W'(COUNT_CAP) : COUNT_W'(MAX_PIXELS);

  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_REMAP = 1'b1;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel;
    logic             last;
  } heq_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] mapped_pixel;
    logic             last_out;
  } heq_res_t;

  typedef struct packed {
    logic             count;
    logic             clear;
    logic [PIX_W-1:0] addr;
  } heq_hist_ctl_t;

endpackage

// ===== rtl/histogram_equalizer_8bit_core.sv =====
// Top level of the two-pass 8-bit histogram equaliser.
`timescale 1ns / 1ps
//
//  channel   signals                  handshake
//  -------   ----------------------   -----------------------------------
//  request   start, busy, request     taken when start is high, busy low
//  result    result_valid, result     one-cycle strobe, cannot be stalled
//
//  Count and remap pixels are taken one per cycle while busy is low; a remap
//  result appears on the cycle after its request. The last count pixel of a
//  pass starts the map build, which holds busy through a wait state for the
//  last bin write to land, then per bin a read of the bin memory, an
//  accumulate, a numerator step, the bit-serial divider and a map write.
//  Reset is synchronous and empties histogram and map through their valid
//  bits.

module histogram_equalizer_8bit_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  heq_pkg::heq_req_t request,
  output logic              result_valid,
  output heq_pkg::heq_res_t result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT,
    S_RD,
    S_ACC,
    S_NUM,
    S_DIV,
    S_WR
  } state_t;

  state_t                      state;
  logic                        accept;
  logic [heq_pkg::COUNT_W-1:0] total;
  logic [heq_pkg::COUNT_W-1:0] cum;
  logic [heq_pkg::PIX_W-1:0]   g;
  logic                        zero_q;
  logic                        last_q;
  heq_pkg::heq_hist_ctl_t      hist_ctl;
  logic [heq_pkg::COUNT_W-1:0] bin;
  logic                        div_start;
  logic                        div_done;
  logic [heq_pkg::PIX_W-1:0]   div_quo;
  logic [heq_pkg::NUM_W-1:0]   num;
  logic                        map_wr;
  logic [heq_pkg::PIX_W-1:0]   map_wdata;
  logic [heq_pkg::PIX_W-1:0]   map_rdata;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    hist_ctl.count = accept && (request.op == heq_pkg::OP_COUNT) &&
                     (total < heq_pkg::COUNT_LIMIT);
    hist_ctl.clear = accept && (request.op == heq_pkg::OP_REMAP) && request.last;
    hist_ctl.addr  = (state == S_RD) ? g : request.pixel;
  end

  // 255*cum + total/2
  assign num = (heq_pkg::NUM_W'(cum) << 8) - heq_pkg::NUM_W'(cum) +
               heq_pkg::NUM_W'(total >> 1);
  assign div_start = (state == S_NUM) && (total != '0);
  assign map_wr    = (state == S_WR);
  assign map_wdata = zero_q ? '0 : div_quo;

  assign result.mapped_pixel = map_rdata;
  assign result.last_out     = last_q;

  heq_hist u_hist (
    .clk (clk),
    .rst (rst),
    .ctl (hist_ctl),
    .bin (bin)
  );

  heq_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (total),
    .done  (div_done),
    .quo   (div_quo)
  );

  heq_map u_map (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (map_wr),
    .wr_addr (g),
    .wr_data (map_wdata),
    .rd_addr (request.pixel),
    .rd_data (map_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      total        <= '0;
      result_valid <= 1'b0;
      g            <= '0;
    end else begin
      result_valid <= accept && (request.op == heq_pkg::OP_REMAP);
      if (hist_ctl.clear) begin
        total <= '0;
      end else if (hist_ctl.count) begin
        total <= total + heq_pkg::COUNT_W'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (request.op == heq_pkg::OP_COUNT) && request.last) begin
            state <= S_WAIT;
            g     <= '0;
          end
        end
        // let the last pixel's bin write land before the walk reads it
        S_WAIT: state <= S_RD;
        S_RD:   state <= S_ACC;
        S_ACC:  state <= S_NUM;
        S_NUM:  state <= (total == '0) ? S_WR : S_DIV;
        S_DIV: begin
          if (div_done) begin
            state <= S_WR;
          end
        end
        S_WR: begin
          g     <= g + heq_pkg::PIX_W'(1);
          state <= (g == heq_pkg::PIX_W'(heq_pkg::BINS - 1)) ? S_IDLE : S_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_q <= request.last;
    end
    if (state == S_WAIT) begin
      cum <= '0;
    end else if (state == S_ACC) begin
      cum <= cum + bin;
    end
    if (state == S_NUM) begin
      zero_q <= (total == '0);
    end
  end

endmodule

// ===== rtl/heq_hist.sv =====
// Histogram bin memory with read-modify-write counting and bypass.
`timescale 1ns / 1ps

module heq_hist (
  input  logic                          clk,
  input  logic                          rst,
  input  heq_pkg::heq_hist_ctl_t        ctl,
  output logic [heq_pkg::COUNT_W-1:0]   bin
);

  logic [heq_pkg::COUNT_W-1:0] mem [heq_pkg::BINS];
  logic [heq_pkg::COUNT_W-1:0] rdata;
  logic [heq_pkg::BINS-1:0]    valid;
  logic [heq_pkg::PIX_W-1:0]   rd_addr;
  logic                        pend;
  logic                        fwd;
  logic [heq_pkg::PIX_W-1:0]   fwd_addr;
  logic [heq_pkg::COUNT_W-1:0] fwd_data;
  logic [heq_pkg::COUNT_W-1:0] bin_inc;

  // take the value written last cycle when it hits the entry just read
  always_comb begin
    if (fwd && (fwd_addr == rd_addr)) begin
      bin = fwd_data;
    end else if (valid[rd_addr]) begin
      bin = rdata;
    end else begin
      bin = '0;
    end
  end

  assign bin_inc = bin + heq_pkg::COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (pend) begin
      mem[rd_addr] <= bin_inc;
    end
    rdata    <= mem[ctl.addr];
    rd_addr  <= ctl.addr;
    fwd_addr <= rd_addr;
    fwd_data <= bin_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      pend  <= 1'b0;
      fwd   <= 1'b0;
    end else begin
      pend <= ctl.count;
      fwd  <= pend && !ctl.clear;
      // a clear drops any write landing in the same cycle
      if (ctl.clear) begin
        valid <= '0;
      end else if (pend) begin
        valid[rd_addr] <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/heq_div.sv =====
// Restoring divider giving an 8-bit quotient, one bit per cycle.
`timescale 1ns / 1ps

module heq_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [heq_pkg::NUM_W-1:0]   num,
  input  logic [heq_pkg::COUNT_W-1:0] den,
  output logic                        done,
  output logic [heq_pkg::PIX_W-1:0]   quo
);

  logic [heq_pkg::NUM_W-1:0]   rem;
  logic [heq_pkg::COUNT_W-1:0] den_q;
  logic [2:0]                  k;
  logic                        run;
  logic [heq_pkg::NUM_W-1:0]   dsh;

  assign dsh = heq_pkg::NUM_W'(den_q) << k;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        k   <= 3'd7;
      end else if (run) begin
        if (k == 3'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        k <= k - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_q <= den;
      quo   <= '0;
    end else if (run && (rem >= dsh)) begin
      rem    <= rem - dsh;
      quo[k] <= 1'b1;
    end
  end

endmodule

// ===== rtl/heq_map.sv =====
// Level map memory; entries not yet written read as zero.
`timescale 1ns / 1ps

module heq_map (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [heq_pkg::PIX_W-1:0] wr_addr,
  input  logic [heq_pkg::PIX_W-1:0] wr_data,
  input  logic [heq_pkg::PIX_W-1:0] rd_addr,
  output logic [heq_pkg::PIX_W-1:0] rd_data
);

  logic [heq_pkg::PIX_W-1:0] mem [heq_pkg::BINS];
  logic [heq_pkg::PIX_W-1:0] rdata;
  logic [heq_pkg::BINS-1:0]  valid;
  logic                      rvalid;

  assign rd_data = rvalid ? rdata : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= valid[rd_addr];
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the two-pass histogram equaliser core.
`timescale 1ns / 1ps

module tb_top;

  class heq_scoreboard;
    logic [heq_pkg::COUNT_W-1:0] bin_count [heq_pkg::BINS];
    logic [heq_pkg::COUNT_W-1:0] pixel_count;
    logic [heq_pkg::PIX_W-1:0]   level_lut [heq_pkg::BINS];
    heq_pkg::heq_res_t           due_q [$];
    int                          errors;
    int                          checked;
    int                          builds;

    function new();
      foreach (level_lut[g]) level_lut[g] = '0;
      clear_hist();
      errors  = 0;
      checked = 0;
      builds  = 0;
    endfunction

    function void clear_hist();
      foreach (bin_count[g]) bin_count[g] = '0;
      pixel_count = '0;
    endfunction

    function void rebuild_levels();
      longint unsigned running;
      longint unsigned whole;
      longint unsigned q;
      running = '0;
      whole   = 64'(pixel_count);
      builds++;
      if (whole == 64'd0) begin
        foreach (level_lut[g]) level_lut[g] = '0;
        return;
      end
      for (int g = 0; g < heq_pkg::BINS; g++) begin
        running += 64'(bin_count[g]);
        q = (64'd255 * running + whole / 64'd2) / whole;
        level_lut[g] = (q > 64'd255) ? 8'd255 : q[heq_pkg::PIX_W-1:0];
      end
    endfunction

    // Update the histogram state and expected results for one accepted request.
    function void note_request(heq_pkg::heq_req_t r);
      heq_pkg::heq_res_t e;
      if (r.op == heq_pkg::OP_COUNT) begin
        // drop counts once the total has saturated
        if (pixel_count < heq_pkg::COUNT_LIMIT) begin
          bin_count[r.pixel] = bin_count[r.pixel] + heq_pkg::COUNT_W'(1);
          pixel_count        = pixel_count + heq_pkg::COUNT_W'(1);
        end
        if (r.last) rebuild_levels();
      end else begin
        e.mapped_pixel = level_lut[r.pixel];
        e.last_out     = r.last;
        due_q.push_back(e);
        if (r.last) clear_hist();
      end
    endfunction

    task report(string msg);
      if (errors < 50) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(heq_pkg::heq_res_t got);
      heq_pkg::heq_res_t want;
      checked++;
      if (due_q.size() == 0) begin
        report($sformatf("result %0d/%0b with none pending", got.mapped_pixel, got.last_out));
        return;
      end
      want = due_q.pop_front();
      if (got.mapped_pixel !== want.mapped_pixel)
        report($sformatf("mapped_pixel %0d, want %0d", got.mapped_pixel, want.mapped_pixel));
      if (got.last_out !== want.last_out)
        report($sformatf("last_out %0b, want %0b", got.last_out, want.last_out));
    endtask

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  heq_pkg::heq_req_t request;
  logic              result_valid;
  heq_pkg::heq_res_t result;

  heq_scoreboard sb = new();

  bit no_gaps;
  int sent;
  int frames;

  histogram_equalizer_8bit_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Check results before noting the request of the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid === 1'b1) sb.check_result(result);
      if (start && busy === 1'b0) sb.note_request(request);
    end
  end

  task automatic put(logic op, logic [heq_pkg::PIX_W-1:0] px, logic lst);
    heq_pkg::heq_req_t r;
    int                gap;
    r.op    = op;
    r.pixel = px;
    r.last  = lst;
    gap     = no_gaps ? 0 : int'($urandom_range(0, 13));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    sent++;
    // hold the request until the core takes it
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_frame(int n_count, int n_remap);
    int                        style;
    int                        spread;
    logic [heq_pkg::PIX_W-1:0] base;
    logic [heq_pkg::PIX_W-1:0] px;
    style  = $urandom_range(0, 2);
    spread = $urandom_range(0, 15);
    base   = heq_pkg::PIX_W'($urandom);
    for (int i = 0; i < n_count; i++) begin
      case (style)
        0: begin
          px = heq_pkg::PIX_W'($urandom);
        end
        1: begin
          px = base + heq_pkg::PIX_W'($urandom_range(0, spread));
        end
        default: begin
          px = ($urandom_range(0, 3) == 0) ? heq_pkg::PIX_W'($urandom) : base;
        end
      endcase
      put(heq_pkg::OP_COUNT, px, i == n_count - 1);
    end
    for (int i = 0; i < n_remap; i++)
      put(heq_pkg::OP_REMAP, heq_pkg::PIX_W'($urandom), i == n_remap - 1);
  endtask

  initial begin
    int pick;
    int nc;
    rst     <= 1'b1;
    start   <= 1'b0;
    request <= '0;
    sent    = 0;
    frames  = 0;
    no_gaps = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // remap through the reset map, last with an empty histogram
    put(heq_pkg::OP_REMAP, 8'h00, 1'b0);
    put(heq_pkg::OP_REMAP, 8'hFF, 1'b0);
    put(heq_pkg::OP_REMAP, 8'h55, 1'b1);
    // small frame with extreme levels
    put(heq_pkg::OP_COUNT, 8'h00, 1'b0);
    put(heq_pkg::OP_COUNT, 8'hFF, 1'b0);
    put(heq_pkg::OP_COUNT, 8'h80, 1'b0);
    put(heq_pkg::OP_COUNT, 8'hFF, 1'b1);
    put(heq_pkg::OP_REMAP, 8'h00, 1'b0);
    put(heq_pkg::OP_REMAP, 8'hFF, 1'b0);
    put(heq_pkg::OP_REMAP, 8'h80, 1'b0);
    put(heq_pkg::OP_REMAP, 8'h01, 1'b0);
    put(heq_pkg::OP_REMAP, 8'hFE, 1'b1);
    // single-pixel frame
    put(heq_pkg::OP_COUNT, 8'hFF, 1'b1);
    put(heq_pkg::OP_REMAP, 8'h00, 1'b0);
    put(heq_pkg::OP_REMAP, 8'hFF, 1'b1);
    // repeated count last, then a remap pass left open
    put(heq_pkg::OP_COUNT, 8'hAA, 1'b1);
    put(heq_pkg::OP_COUNT, 8'h55, 1'b1);
    put(heq_pkg::OP_REMAP, 8'hAA, 1'b0);
    put(heq_pkg::OP_REMAP, 8'h55, 1'b0);
    put(heq_pkg::OP_COUNT, 8'h0F, 1'b1);
    put(heq_pkg::OP_REMAP, 8'h0F, 1'b0);
    put(heq_pkg::OP_REMAP, 8'hF0, 1'b1);
    drain();

    while (sent < 730) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      pick    = $urandom_range(0, 9);
      if (pick < 8) begin
        nc = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
        run_frame(nc, $urandom_range(1, 40));
        frames++;
      end else begin
        // noise: arbitrary ops, broken passes
        repeat ($urandom_range(1, 6))
          put(1'($urandom), heq_pkg::PIX_W'($urandom), $urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 5) == 0) drain();
    end

    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    // let a trailing map build finish and catch stray results
    repeat (3400) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("Sent %0d requests (%0d well-formed frames plus noise), %0d map builds.",
             sent, frames, sb.builds);
    $display("Compared %0d remapped pixels, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #500_000_000;
    $display("Timeout: run did not complete.");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
